// ----- hw/rtl/name_number_record_parser_defines.svh -----
// ============================================================================
// name_number_record_parser_defines.svh
// Assertion macros shared by the record parser's job queue and back end.
// ============================================================================
`ifndef NAME_NUMBER_RECORD_PARSER_DEFINES_SVH
`define NAME_NUMBER_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define NNRP_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NNRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnrp assertion failed");

`else

`define NNRP_ASSERT(label, clk, rst_n, ante, cons)
`define NNRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/nnrp_pkg.sv -----
// ============================================================================
// nnrp_pkg
// Types and constants shared by the record parser modules.
// ============================================================================
package nnrp_pkg;

  localparam int NAME_BYTES_MAX_DEF = 64;
  localparam int JOBQ_DEPTH         = 2;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_COMMA  = 3'd1;
  localparam logic [2:0] ST_LONG   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_FORMAT = 3'd4;
  localparam logic [2:0] ST_OVER   = 3'd5;

  // Bit positions in the per-line error flags.
  localparam int ERR_LONG   = 0;
  localparam int ERR_EMPTY  = 1;
  localparam int ERR_FORMAT = 2;
  localparam int ERR_OVER   = 3;

  typedef enum logic [3:0] {
    PH_NAME        = 4'b0001,
    PH_AFTER_COMMA = 4'b0010,
    PH_SPACES      = 4'b0100,
    PH_BODY        = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    RUN_NONE   = 3'b001,
    RUN_ACTIVE = 3'b010,
    RUN_DONE   = 3'b100
  } run_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_NAME  = 3'b010,
    BK_FINAL = 3'b100
  } back_state_t;

  // Back end hands a name bank back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

// ----- hw/rtl/nnrp_front.sv -----
// ============================================================================
// nnrp_front
// Byte classifier and line parser; writes name bytes and queues line jobs.
// ============================================================================
module nnrp_front #(
  parameter int NAME_BYTES_MAX = nnrp_pkg::NAME_BYTES_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_text_byte,
  output logic                                  wr_en,
  output logic                                  wr_bank,
  output logic [((NAME_BYTES_MAX > 2) ? $clog2(NAME_BYTES_MAX - 1) : 1)-1:0] wr_idx,
  output logic [7:0]                            wr_data,
  output logic                                  job_push,
  output logic [1 + $clog2(NAME_BYTES_MAX) + 64 + 3 - 1:0] job_data,
  input  logic                                  q_full,
  input  nnrp_pkg::rel_t                        rel
);
  import nnrp_pkg::*;

  localparam int DEPTH = NAME_BYTES_MAX - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(NAME_BYTES_MAX);
  localparam int CW    = $clog2(NAME_BYTES_MAX + 1);
  localparam logic [CW-1:0] LEN_KEEP = CW'(NAME_BYTES_MAX - 1);
  localparam logic [CW-1:0] LEN_MAX  = CW'(NAME_BYTES_MAX);

  logic [CW-1:0] name_len_r, name_len_nxt;
  logic [1:0]    comma_cnt_r, comma_cnt_nxt;
  phase_t        phase_r, phase_nxt;
  logic          plus_r, plus_nxt;
  run_t          run_r, run_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [3:0]    err_r, err_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          accept;
  logic          is_digit;
  logic [3:0]    digit;
  logic [67:0]   prod;
  logic [3:0]    flags;
  logic [2:0]    status;
  logic          in_body;
  run_t          run_eff;

  assign in_ready = !busy_r[bank_r] && !q_full;
  assign accept   = in_valid && in_ready;
  assign is_digit = (in_text_byte >= CH_ZERO) && (in_text_byte <= CH_NINE);
  assign digit    = in_text_byte[3:0];
  assign prod     = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {64'd0, digit};

  // Final flags and status of the line, valid when the newline arrives.
  always_comb begin
    flags = err_r;
    if (phase_r == PH_AFTER_COMMA) begin
      flags[ERR_EMPTY] = 1'b1;
    end
    if (plus_r) begin
      flags[ERR_FORMAT] = 1'b1;
    end
    if (comma_cnt_r != 2'd1) begin
      status = ST_COMMA;
    end else if (flags[ERR_LONG]) begin
      status = ST_LONG;
    end else if (flags[ERR_EMPTY]) begin
      status = ST_EMPTY;
    end else if (flags[ERR_FORMAT]) begin
      status = ST_FORMAT;
    end else if (flags[ERR_OVER]) begin
      status = ST_OVER;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    name_len_nxt  = name_len_r;
    comma_cnt_nxt = comma_cnt_r;
    phase_nxt     = phase_r;
    plus_nxt      = plus_r;
    run_nxt       = run_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    bank_nxt      = bank_r;
    busy_nxt      = busy_r;
    wr_en         = 1'b0;
    wr_bank       = bank_r;
    wr_idx        = name_len_r[AW-1:0];
    wr_data       = in_text_byte;
    job_push      = 1'b0;
    job_data      = {bank_r,
                     (status == ST_OK) ? name_len_r[LW-1:0] : LW'(0),
                     (status == ST_OK) ? acc_r : 64'd0,
                     status};
    in_body       = 1'b0;
    run_eff       = run_r;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (in_text_byte == CH_NL) begin
        job_push         = 1'b1;
        busy_nxt[bank_r] = 1'b1;
        bank_nxt         = !bank_r;
        name_len_nxt     = '0;
        comma_cnt_nxt    = 2'd0;
        phase_nxt        = PH_NAME;
        plus_nxt         = 1'b0;
        run_nxt          = RUN_NONE;
        acc_nxt          = 64'd0;
        err_nxt          = 4'd0;
      end else if (in_text_byte == CH_COMMA) begin
        if (comma_cnt_r != 2'd2) begin
          comma_cnt_nxt = comma_cnt_r + 2'd1;
        end
        if (phase_r == PH_NAME) begin
          phase_nxt = PH_AFTER_COMMA;
        end
      end else if (phase_r == PH_NAME) begin
        if (name_len_r < LEN_KEEP) begin
          wr_en = 1'b1;
        end
        if (name_len_r < LEN_MAX) begin
          name_len_nxt = name_len_r + CW'(1);
        end
        if (name_len_r >= LEN_KEEP) begin
          err_nxt[ERR_LONG] = 1'b1;
        end
      end else if ((phase_r == PH_AFTER_COMMA) || (phase_r == PH_SPACES)) begin
        if (in_text_byte == CH_SPACE) begin
          phase_nxt = PH_SPACES;
        end else begin
          phase_nxt = PH_BODY;
          in_body   = 1'b1;
        end
      end else begin
        in_body = 1'b1;
      end

      if (in_body) begin
        if (plus_r) begin
          plus_nxt = 1'b0;
          if (!is_digit) begin
            err_nxt[ERR_FORMAT] = 1'b1;
          end
        end
        if (is_digit) begin
          run_eff = (run_r == RUN_NONE) ? RUN_ACTIVE : run_r;
          run_nxt = run_eff;
          if ((run_eff == RUN_ACTIVE) && !err_r[ERR_OVER]) begin
            if (prod[67:64] != 4'd0) begin
              err_nxt[ERR_OVER] = 1'b1;
            end else begin
              acc_nxt = prod[63:0];
            end
          end
        end else if (in_text_byte == CH_PLUS) begin
          plus_nxt = 1'b1;
          if (run_r == RUN_ACTIVE) begin
            run_nxt = RUN_DONE;
          end
        end else begin
          err_nxt[ERR_FORMAT] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r  <= '0;
      comma_cnt_r <= 2'd0;
      phase_r     <= PH_NAME;
      plus_r      <= 1'b0;
      run_r       <= RUN_NONE;
      acc_r       <= 64'd0;
      err_r       <= 4'd0;
      bank_r      <= 1'b0;
      busy_r      <= 2'b00;
    end else begin
      name_len_r  <= name_len_nxt;
      comma_cnt_r <= comma_cnt_nxt;
      phase_r     <= phase_nxt;
      plus_r      <= plus_nxt;
      run_r       <= run_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      bank_r      <= bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

// ----- hw/rtl/nnrp_job_fifo.sv -----
// ============================================================================
// nnrp_job_fifo
// Short queue of finished line jobs between parser and emitter.
// ============================================================================
`include "name_number_record_parser_defines.svh"

module nnrp_job_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  import nnrp_pkg::*;

  localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int NW = $clog2(JOBQ_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(JOBQ_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(JOBQ_DEPTH - 1);

  logic [W-1:0]  ent_r [JOBQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == DEPTH_N);
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `NNRP_ASSERT(a_no_overflow, clk, rst_n, push, !full || pop)
  `NNRP_ASSERT(a_no_underflow, clk, rst_n, pop, !empty)
  `NNRP_ASSERT(a_count_bound, clk, rst_n, 1'b1, cnt_r <= DEPTH_N)

endmodule

// ----- hw/rtl/nnrp_back.sv -----
// ============================================================================
// nnrp_back
// Name store and emitter: replays the name bytes, then the final record.
// ============================================================================
`include "name_number_record_parser_defines.svh"

module nnrp_back #(
  parameter int NAME_BYTES_MAX = nnrp_pkg::NAME_BYTES_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic                                  wr_bank,
  input  logic [((NAME_BYTES_MAX > 2) ? $clog2(NAME_BYTES_MAX - 1) : 1)-1:0] wr_idx,
  input  logic [7:0]                            wr_data,
  input  logic [1 + $clog2(NAME_BYTES_MAX) + 64 + 3 - 1:0] job_data,
  input  logic                                  q_empty,
  output logic                                  job_pop,
  output nnrp_pkg::rel_t                        rel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_is_name_char,
  output logic [7:0]                            out_name_char,
  output logic [63:0]                           out_value,
  output logic [2:0]                            out_status,
  output logic                                  out_last
);
  import nnrp_pkg::*;

  localparam int DEPTH = NAME_BYTES_MAX - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(NAME_BYTES_MAX);

  logic [7:0] mem_r [2][DEPTH];
  logic [7:0] rd_q_r;

  back_state_t st_r, st_nxt;
  logic          bank_r, bank_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [63:0]   value_r, value_nxt;
  logic [2:0]    status_r, status_nxt;

  logic          ov_r, ov_nxt;
  logic          o_is_name_r, o_is_name_nxt;
  logic [7:0]    o_char_r, o_char_nxt;
  logic [63:0]   o_value_r, o_value_nxt;
  logic [2:0]    o_status_r, o_status_nxt;
  logic          o_last_r, o_last_nxt;

  logic          slot_free;
  logic          j_bank;
  logic [LW-1:0] j_count;
  logic [63:0]   j_value;
  logic [2:0]    j_status;

  assign {j_bank, j_count, j_value, j_status} = job_data;
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    st_nxt        = st_r;
    bank_nxt      = bank_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    ov_nxt        = ov_r && !out_ready;
    o_is_name_nxt = o_is_name_r;
    o_char_nxt    = o_char_r;
    o_value_nxt   = o_value_r;
    o_status_nxt  = o_status_r;
    o_last_nxt    = o_last_r;
    job_pop       = 1'b0;
    rel.valid     = 1'b0;
    rel.bank      = bank_r;

    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          job_pop    = 1'b1;
          bank_nxt   = j_bank;
          count_nxt  = j_count;
          value_nxt  = j_value;
          status_nxt = j_status;
          idx_nxt    = '0;
          st_nxt     = (j_count == '0) ? BK_FINAL : BK_NAME;
        end
      end
      BK_NAME: begin
        if (slot_free) begin
          ov_nxt        = 1'b1;
          o_is_name_nxt = 1'b1;
          o_char_nxt    = rd_q_r;
          o_value_nxt   = 64'd0;
          o_status_nxt  = ST_OK;
          o_last_nxt    = 1'b0;
          if (idx_r == count_r - LW'(1)) begin
            st_nxt = BK_FINAL;
          end else begin
            idx_nxt = idx_r + LW'(1);
          end
        end
      end
      BK_FINAL: begin
        if (slot_free) begin
          ov_nxt        = 1'b1;
          o_is_name_nxt = 1'b0;
          o_char_nxt    = 8'd0;
          o_value_nxt   = value_r;
          o_status_nxt  = status_r;
          o_last_nxt    = 1'b1;
          rel.valid     = 1'b1;
          st_nxt        = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  // The read address follows the next index, so rd_q_r holds the byte at idx_r.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_bank][wr_idx] <= wr_data;
    end
    rd_q_r <= mem_r[bank_nxt][idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r      <= bank_nxt;
    count_r     <= count_nxt;
    value_r     <= value_nxt;
    status_r    <= status_nxt;
    o_is_name_r <= o_is_name_nxt;
    o_char_r    <= o_char_nxt;
    o_value_r   <= o_value_nxt;
    o_status_r  <= o_status_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_is_name_char = o_is_name_r;
  assign out_name_char    = o_char_r;
  assign out_value        = o_value_r;
  assign out_status       = o_status_r;
  assign out_last         = o_last_r;

  `NNRP_ASSERT(a_idx_in_range, clk, rst_n, st_r == BK_NAME, idx_r < count_r)
  `NNRP_ASSERT_NEXT(a_release_emits_final, clk, rst_n, rel.valid, ov_r && o_last_r)
  `NNRP_ASSERT(a_name_result_clean, clk, rst_n, ov_r && o_is_name_r,
               (o_status_r == ST_OK) && (o_value_r == 64'd0) && !o_last_r)

endmodule

// ----- hw/rtl/name_number_record_parser.sv -----
// ============================================================================
// name_number_record_parser
// Parses "name,number" text lines into name-byte results and a final record.
// Bytes arrive one per transaction on the input channel and a newline byte
// ends a line. The front end accepts one byte per cycle, classifies it and
// keeps the line state; name bytes (up to NAME_BYTES_MAX-1) are written into
// one of two name banks. At the newline it queues a job holding the name
// length, the value and the status. The back end replays the name bytes from
// the bank and then one final record with last set; a line with an error
// yields the final record alone. The back end takes a job from the queue
// only when idle, then loads the line's results in order into its output
// register while that register is free, so it finishes one line before it
// takes the next job. The first result of a line passes from the job queue
// through the back end's job registers into the output register. A bank is
// freed once its line's final record has been loaded into the output
// register. The front end stalls only when both name banks hold lines whose
// final records have not yet been loaded, so sustained throughput is set by
// the output side for lines with few bytes, as for a lone newline.
// Status codes: 0 ok, 1 comma count, 2 name too long, 3 empty number,
// 4 bad number format, 5 overflow. No clearing pass is needed after reset.
// ============================================================================
module name_number_record_parser #(
  parameter int NAME_BYTES_MAX = nnrp_pkg::NAME_BYTES_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_name_char,
  output logic [7:0]  out_name_char,
  output logic [63:0] out_value,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import nnrp_pkg::*;

  localparam int DEPTH = NAME_BYTES_MAX - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(NAME_BYTES_MAX);
  localparam int JW    = 1 + LW + 64 + 3;

  // Name-store write port from the front end.
  logic          wr_en;
  logic          wr_bank;
  logic [AW-1:0] wr_idx;
  logic [7:0]    wr_data;

  // Job queue between the two halves.
  logic          job_push;
  logic [JW-1:0] job_in;
  logic          job_pop;
  logic [JW-1:0] job_out;
  logic          q_full;
  logic          q_empty;

  // Bank release from the back end once a line's final record is loaded.
  rel_t          rel;

  nnrp_front #(
    .NAME_BYTES_MAX (NAME_BYTES_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .wr_en        (wr_en),
    .wr_bank      (wr_bank),
    .wr_idx       (wr_idx),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job_data     (job_in),
    .q_full       (q_full),
    .rel          (rel)
  );

  nnrp_job_fifo #(
    .W (JW)
  ) u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  nnrp_back #(
    .NAME_BYTES_MAX (NAME_BYTES_MAX)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (wr_en),
    .wr_bank          (wr_bank),
    .wr_idx           (wr_idx),
    .wr_data          (wr_data),
    .job_data         (job_out),
    .q_empty          (q_empty),
    .job_pop          (job_pop),
    .rel              (rel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_name_char (out_is_name_char),
    .out_name_char    (out_name_char),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// ----- dv/tb_name_number_record_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_name_number_record_parser
// Feeds text lines of the form name,number into the record parser one byte
// per transaction. Each accepted byte updates a line parser kept inside this
// bench. At a newline that parser queues the name bytes it expects and the
// closing record. Every result leaving the block is checked field by field
// against the oldest queued expectation. The run starts with short directed
// lines for the corner cases. Random lines follow under several patterns of
// sender gaps and receiver stalls.
// ============================================================================
module tb_name_number_record_parser;
  import nnrp_pkg::*;

  localparam int NAME_MAX     = NAME_BYTES_MAX_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 4;
  localparam int TAIL_CYCLES  = 16;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic        is_name;
    logic [7:0]  name_char;
    logic [63:0] value;
    logic [2:0]  status;
    logic        last;
  } parse_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_name_char;
  logic [7:0]  out_name_char;
  logic [63:0] out_value;
  logic [2:0]  out_status;
  logic        out_last;

  // Bytes waiting to be offered, and results the parser still owes us.
  logic [7:0]  pending_bytes[$];
  parse_out_t  expected_out[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int lines_parsed = 0;
  int cycle_count = 0;
  int status_hits[6];

  // Line state of the bench's own parser.
  logic [7:0]  name_buf[0:NAME_MAX-2];
  int          name_len = 0;
  int          commas = 0;
  phase_t      scan = PH_NAME;
  run_t        run = RUN_NONE;
  logic        plus_wait = 1'b0;
  logic [63:0] acc = '0;
  logic [3:0]  errs = '0;

  name_number_record_parser #(
    .NAME_BYTES_MAX(NAME_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_name_char (out_is_name_char),
    .out_name_char    (out_name_char),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advances the line parser by one accepted byte. A newline closes the line:
  // the status is chosen by priority, the name is replayed only for a good
  // line, and the closing record always follows.
  function automatic void predict_byte(input logic [7:0] c);
    parse_out_t  r;
    logic [2:0]  st;
    logic [63:0] d;
    logic        is_dig;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_COMMA) begin
      if (commas < 2) commas++;
      if (scan == PH_NAME) scan = PH_AFTER_COMMA;
    end else if (c != CH_NL && scan == PH_NAME) begin
      // Only the first NAME_MAX-1 name bytes are stored; one more marks
      // the name as too long.
      if (name_len < NAME_MAX - 1) name_buf[name_len] = c;
      if (name_len < NAME_MAX) name_len++;
      if (name_len > NAME_MAX - 1) errs[ERR_LONG] = 1'b1;
    end else if (c != CH_NL && (scan == PH_AFTER_COMMA || scan == PH_SPACES)
                 && c == CH_SPACE) begin
      scan = PH_SPACES;
    end else if (c != CH_NL) begin
      scan = PH_BODY;
      // A plus must be followed directly by a digit.
      if (plus_wait) begin
        plus_wait = 1'b0;
        if (!is_dig) errs[ERR_FORMAT] = 1'b1;
      end
      if (is_dig) begin
        d = 64'(c - CH_ZERO);
        if (run == RUN_NONE) run = RUN_ACTIVE;
        // Only the first digit run counts toward the value.
        if (run == RUN_ACTIVE && !errs[ERR_OVER]) begin
          if (acc > (U64_MAX - d) / 64'd10) errs[ERR_OVER] = 1'b1;
          else acc = acc * 64'd10 + d;
        end
      end else if (c == CH_PLUS) begin
        plus_wait = 1'b1;
        if (run == RUN_ACTIVE) run = RUN_DONE;
      end else begin
        errs[ERR_FORMAT] = 1'b1;
      end
    end else begin
      if (scan == PH_AFTER_COMMA) errs[ERR_EMPTY] = 1'b1;
      if (plus_wait) errs[ERR_FORMAT] = 1'b1;
      if (commas != 1)          st = ST_COMMA;
      else if (errs[ERR_LONG])   st = ST_LONG;
      else if (errs[ERR_EMPTY])  st = ST_EMPTY;
      else if (errs[ERR_FORMAT]) st = ST_FORMAT;
      else if (errs[ERR_OVER])   st = ST_OVER;
      else                       st = ST_OK;
      if (st == ST_OK) begin
        for (int i = 0; i < name_len && i < NAME_MAX - 1; i++) begin
          r = '{is_name: 1'b1, name_char: name_buf[i], value: '0, status: ST_OK,
                last: 1'b0};
          expected_out.push_back(r);
        end
      end
      r = '{is_name: 1'b0, name_char: 8'h00, value: (st == ST_OK) ? acc : '0,
            status: st, last: 1'b1};
      expected_out.push_back(r);
      status_hits[st]++;
      lines_parsed++;
      name_len = 0;
      commas = 0;
      scan = PH_NAME;
      run = RUN_NONE;
      plus_wait = 1'b0;
      acc = '0;
      errs = '0;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // A name of n random bytes; newline and comma are kept out so that the
  // name stays one field of one line.
  function automatic void push_name(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_NL || b == CH_COMMA);
      push_byte(b);
    end
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // Mostly well-formed lines with random content, the rest noise built from
  // the bytes the parser cares about plus arbitrary ones.
  function automatic void push_random_line();
    int         ndig;
    int         sel;
    logic [7:0] b;
    if ($urandom_range(0, 99) < 72) begin
      if ($urandom_range(0, 24) == 0) push_name($urandom_range(60, 66));
      else push_name($urandom_range(0, 8));
      push_byte(CH_COMMA);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_byte(CH_SPACE);
      if ($urandom_range(0, 3) == 0) push_byte(CH_PLUS);
      if ($urandom_range(0, 6) == 0) begin
        // Twenty digits or so: straddles the 64-bit limit.
        ndig = $urandom_range(19, 21);
        push_byte(8'(CH_ZERO + $urandom_range(1, 2)));
        push_digits(ndig - 1);
      end else begin
        push_digits($urandom_range(0, 5));
      end
      if ($urandom_range(0, 4) == 0) begin
        push_byte(CH_PLUS);
        push_digits($urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
        push_byte(b);
      end
    end else begin
      repeat ($urandom_range(1, 10)) begin
        sel = $urandom_range(0, 4);
        case (sel)
          0: begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
            push_byte(b);
          end
          1: push_byte(CH_COMMA);
          2: push_byte(CH_SPACE);
          3: push_byte(CH_PLUS);
          default: push_digits(1);
        endcase
      end
    end
    push_byte(CH_NL);
  endfunction

  // Holds the sender off until every queued byte is taken and every result
  // it caused has been checked.
  task automatic wait_drained();
    wait (pending_bytes.size() == 0 && bytes_taken == bytes_queued &&
          expected_out.size() == 0);
    @(negedge clk);
  endtask

  // Driver: a byte that is accepted goes to the parser model, then the next
  // one is offered unless this cycle is chosen as a gap. Valid only drops
  // when the current byte has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(in_text_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_text_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation and
  // draws the next ready at random.
  always @(posedge clk) begin
    parse_out_t got;
    parse_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{is_name: out_is_name_char, name_char: out_name_char,
                value: out_value, status: out_status, last: out_last};
        results_checked++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: is_name=%0b char=%02h value=%0d status=%0d last=%0b",
                     $realtime, got.is_name, got.name_char, got.value, got.status, got.last);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected: is_name=%0b char=%02h value=%0d status=%0d last=%0b",
                       want.is_name, want.name_char, want.value, want.status, want.last);
              $display("  actual:   is_name=%0b char=%02h value=%0d status=%0d last=%0b",
                       got.is_name, got.name_char, got.value, got.status, got.last);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_out.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int in_pcts[4];
    int out_pcts[4];
    int phase_start;
    int leftover;
    in_pcts = '{0, 46, 0, 38};
    out_pcts = '{0, 0, 46, 38};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines, no gaps on either side.
    push_text("a,1\n");                         // plain good line
    push_text("ab\n");                          // no comma
    push_text(",\n");                           // nothing after the comma
    push_text("x,+\n");                         // plus at end of line
    push_text("x,1+2\n");                       // later run is not added
    push_text("x,18446744073709551616\n");      // one past the largest value
    push_name(NAME_MAX);                        // too long, and empty number
    push_text(",\n");
    wait_drained();

    // Random lines under each gap pattern; between patterns the sender
    // waits until every result has come back.
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = in_pcts[ph];
      out_stall_pct = out_pcts[ph];
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) push_random_line();
      wait_drained();
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    leftover = expected_out.size();
    if (leftover != 0)
      $display("%0d expected results never arrived", leftover);

    $display("Parsed %0d lines from %0d bytes and checked %0d results, %0d mismatching.",
             lines_parsed, bytes_taken, results_checked, mismatches);
    $display("Closing records by status ok/comma/long/empty/format/overflow: %0d/%0d/%0d/%0d/%0d/%0d",
             status_hits[ST_OK], status_hits[ST_COMMA], status_hits[ST_LONG],
             status_hits[ST_EMPTY], status_hits[ST_FORMAT], status_hits[ST_OVER]);
    if (mismatches == 0 && leftover == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
